FILE: design/mceb_pkg.sv
// ----------------------------------------------------------------------------
// mceb_pkg
// Shared types, constants and helpers for the colour expansion blit core.
// ----------------------------------------------------------------------------
package mceb_pkg;

  localparam bit BIG_ENDIAN_LAYOUT = 1'b0;

  localparam int COLOR_W   = 32;
  localparam int ADDR_W    = 32;
  localparam int BPP_W     = 3;
  localparam int STRIDE_W  = 16;
  localparam int POS_W     = 14;
  localparam int WIDTH_W   = 15;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;
  localparam int PRODX_W   = WIDTH_W + BPP_W;
  localparam int PRODY_W   = POS_W + STRIDE_W;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(16384);
  localparam logic [BPP_W-1:0]   BPP_MAX   = BPP_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR   = 4'd0,
    REG_BG_COLOR   = 4'd1,
    REG_OPAQUE     = 4'd2,
    REG_BPP        = 4'd3,
    REG_STRIDE     = 4'd4,
    REG_DEST_X     = 4'd5,
    REG_DEST_Y     = 4'd6,
    REG_RECT_WIDTH = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;
    logic                opaque_mode;
    logic [BPP_W-1:0]    pixel_bytes;
    logic [STRIDE_W-1:0] line_stride;
    logic [POS_W-1:0]    dest_x;
    logic [POS_W-1:0]    dest_y;
    logic [WIDTH_W-1:0]  rect_width;
  } cfg_t;

  // one write waiting between front and back
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [WIDTH_W-1:0] col_off;
    logic [ADDR_W-1:0]  line_base;
  } entry_t;

  function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] bpp);
    if (bpp >= BPP_W'(1) && bpp <= BPP_MAX) begin
      return bpp;
    end
    return BPP_MAX;
  endfunction

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    if (w == '0) begin
      return WIDTH_W'(1);
    end
    if (w > MAX_WIDTH) begin
      return MAX_WIDTH;
    end
    return w;
  endfunction

  function automatic logic [COLOR_W-1:0] pack_pixel(input logic [COLOR_W-1:0] pix,
                                                    input logic [BPP_W-1:0]   bpp);
    logic [COLOR_W-1:0] res;
    case (bpp)
      3'd1: res = {24'h0, pix[7:0]};
      3'd2: res = {16'h0, pix[15:0]};
      3'd3: begin
        if (BIG_ENDIAN_LAYOUT) begin
          res = {8'h0, pix[7:0], pix[15:8], pix[23:16]};
        end else begin
          res = {8'h0, pix[23:0]};
        end
      end
      default: res = pix;
    endcase
    return res;
  endfunction

endpackage

FILE: design/mceb_ifs.sv
// ----------------------------------------------------------------------------
// mceb interfaces
// Pixel input, write output and configuration channels.
// ----------------------------------------------------------------------------
interface mceb_pix_if;
  logic valid;
  logic ready;
  logic source_bit;
  logic last_pixel;
  modport source (output valid, output source_bit, output last_pixel, input ready);
  modport sink   (input valid, input source_bit, input last_pixel, output ready);
endinterface

interface mceb_wr_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_address;
  logic [31:0] write_data;
  logic [2:0]  byte_count;
  modport source (output valid, output byte_address, output write_data,
                  output byte_count, input ready);
  modport sink   (input valid, input byte_address, input write_data,
                  input byte_count, output ready);
endinterface

interface mceb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/mono_color_expansion_blit_core.sv
// an accepted pixel item goes through the queue, back stage s1 and the output register
// throughput: one pixel item per cycle while the queue is not full; the 4-entry
// queue and two back stages absorb output stalls before the input stalls
// transparent clear bits advance the position and give no write item
// reset (rst, synchronous): position, queue and pipeline cleared, registers to defaults
// ----------------------------------------------------------------------------
// mono_color_expansion_blit_core
// Monochrome colour expansion blit: register file, front, queue and back.
// ----------------------------------------------------------------------------
module mono_color_expansion_blit_core
  import mceb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mceb_pix_if.sink      pix_in,
  mceb_wr_if.source     wr_out,
  mceb_cfg_if.sink      cfg
);

  cfg_t   regs;
  logic   q_push;
  entry_t q_entry;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fg_color        <= '0;
      regs.bg_color        <= '0;
      regs.opaque_mode     <= 1'b0;
      regs.pixel_bytes     <= BPP_MAX;
      regs.line_stride     <= '0;
      regs.dest_x          <= '0;
      regs.dest_y          <= '0;
      regs.rect_width      <= WIDTH_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_FG_COLOR:   regs.fg_color        <= cfg.data[COLOR_W-1:0];
        REG_BG_COLOR:   regs.bg_color        <= cfg.data[COLOR_W-1:0];
        REG_OPAQUE:     regs.opaque_mode     <= cfg.data[0];
        REG_BPP:        regs.pixel_bytes     <= cfg.data[BPP_W-1:0];
        REG_STRIDE:     regs.line_stride     <= cfg.data[STRIDE_W-1:0];
        REG_DEST_X:     regs.dest_x          <= cfg.data[POS_W-1:0];
        REG_DEST_Y:     regs.dest_y          <= cfg.data[POS_W-1:0];
        REG_RECT_WIDTH: regs.rect_width      <= cfg.data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  mceb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .source_bit (pix_in.source_bit),
    .last_pixel (pix_in.last_pixel),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  mceb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  mceb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (regs),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (wr_out.valid),
    .out_ready    (wr_out.ready),
    .byte_address (wr_out.byte_address),
    .write_data   (wr_out.write_data),
    .byte_count   (wr_out.byte_count)
  );

endmodule

FILE: design/mceb_front.sv
// ----------------------------------------------------------------------------
// mceb_front
// Accepts pixel items, tracks the raster position and queues the writes.
// ----------------------------------------------------------------------------
module mceb_front
  import mceb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   source_bit,
  input  logic   last_pixel,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  logic [POS_W-1:0]   column_pos;
  logic [ADDR_W-1:0]  line_base_addr;
  logic               accept;
  logic [WIDTH_W-1:0] col_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign col_inc  = {1'b0, column_pos} + WIDTH_W'(1);

  assign q_push            = accept && (source_bit || cfg.opaque_mode);
  assign q_entry.color     = source_bit ? cfg.fg_color : cfg.bg_color;
  assign q_entry.col_off   = {1'b0, cfg.dest_x} + {1'b0, column_pos};
  assign q_entry.line_base = line_base_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos     <= '0;
      line_base_addr <= '0;
    end else if (accept) begin
      if (last_pixel) begin
        column_pos     <= '0;
        line_base_addr <= '0;
      end else if (col_inc >= eff_width(cfg.rect_width)) begin
        column_pos     <= '0;
        line_base_addr <= line_base_addr + {{(ADDR_W-STRIDE_W){1'b0}}, cfg.line_stride};
      end else begin
        column_pos <= col_inc[POS_W-1:0];
      end
    end
  end

endmodule

FILE: design/mceb_queue.sv
// ----------------------------------------------------------------------------
// mceb_queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module mceb_queue
  import mceb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: design/mceb_back.sv
// ----------------------------------------------------------------------------
// mceb_back
// Two-stage write builder: products and packing, then address sum.
// ----------------------------------------------------------------------------
module mceb_back
  import mceb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  entry_t             q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ADDR_W-1:0]  byte_address,
  output logic [COLOR_W-1:0] write_data,
  output logic [BPP_W-1:0]   byte_count
);

  logic               s1_valid;
  logic [PRODX_W-1:0] s1_prod_x;
  logic [PRODY_W-1:0] s1_prod_y;
  logic [ADDR_W-1:0]  s1_base;
  logic [COLOR_W-1:0] s1_data;
  logic [BPP_W-1:0]   s1_bpp;
  logic               o_free;
  logic               s1_ready;
  logic [BPP_W-1:0]   bpp;

  assign bpp      = eff_bpp(cfg.pixel_bytes);
  assign o_free   = !out_valid || out_ready;
  assign s1_ready = !s1_valid || o_free;
  assign q_pop    = !q_empty && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= !q_empty;
      end
      if (o_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod_x <= PRODX_W'(q_head.col_off) * PRODX_W'(bpp);
      s1_prod_y <= PRODY_W'(cfg.dest_y) * PRODY_W'(cfg.line_stride);
      s1_base   <= q_head.line_base;
      s1_data   <= pack_pixel(q_head.color, bpp);
      s1_bpp    <= bpp;
    end
    if (o_free && s1_valid) begin
      byte_address <= {{(ADDR_W-PRODY_W){1'b0}}, s1_prod_y} + s1_base
                      + {{(ADDR_W-PRODX_W){1'b0}}, s1_prod_x};
      write_data   <= s1_data;
      byte_count   <= s1_bpp;
    end
  end

endmodule
